@@ src/apic_pkg.sv @@
// Package for the interrupt priority core: sizes, function codes, register map,
// the command and status structs between controller and datapath, and helpers.
// Depends on nothing; every other file of the block imports it.
package apic_pkg;

   localparam int NUM_VECTORS   = 256;
   localparam int BITS_PER_WORD = 32;
   localparam int NUM_WORDS     = (NUM_VECTORS + BITS_PER_WORD - 1) / BITS_PER_WORD;
   localparam int WORD_IDX_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int BIT_W         = $clog2(BITS_PER_WORD);
   localparam int VEC_W         = 8;
   localparam int FUNC_W        = 2;
   localparam int PRIO_W        = 8;
   localparam int CSR_ADDR_W    = 3;
   localparam int CSR_DATA_W    = 32;

   localparam logic [PRIO_W-1:0] CLASS_MASK = 8'hF0;
   localparam logic [PRIO_W-1:0] PRIO_MASK  = 8'hFF;

   localparam logic CSR_IDX_UNIT_ENABLE = 1'b0;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_RAISE    = 2'd0,
      FUNC_ACK      = 2'd1,
      FUNC_EOI      = 2'd2,
      FUNC_SET_TASK = 2'd3
   } apic_func_type;

   typedef logic [BITS_PER_WORD-1:0] apic_word_type;

   typedef struct packed {
      logic load;
      logic scan_clear;
      logic scan_step;
      logic apply;
      logic post;
   } apic_cmd_type;

   typedef struct packed {
      logic pre_scan;
      logic scan_last;
   } apic_status_type;

   function automatic logic [BIT_W-1:0] highest_bit(input apic_word_type word);
      logic [BIT_W-1:0] pos;
      pos = '0;
      for (int i = 0; i < BITS_PER_WORD; i++) begin
         if (word[i]) begin
            pos = BIT_W'(i);
         end
      end
      return pos;
   endfunction

endpackage

@@ src/apic_if.sv @@
// Handshake interfaces for the request and response channels of the core.
// Depends on apic_pkg for the field types.
interface apic_req_if;
   import apic_pkg::*;

   logic                valid;
   logic                ready;
   apic_func_type       func;
   logic [VEC_W-1:0]    vector;
   logic [PRIO_W-1:0]   task_priority;

   modport source (output valid, output func, output vector, output task_priority,
                   input ready);
   modport sink   (input valid, input func, input vector, input task_priority,
                   output ready);
endinterface

interface apic_rsp_if;
   import apic_pkg::*;

   logic                valid;
   logic                ready;
   logic                accepted;
   logic                vector_valid;
   logic [VEC_W-1:0]    vector_out;
   logic [PRIO_W-1:0]   processor_priority;
   logic                interrupt_ready;

   modport source (output valid, output accepted, output vector_valid, output vector_out,
                   output processor_priority, output interrupt_ready, input ready);
   modport sink   (input valid, input accepted, input vector_valid, input vector_out,
                   input processor_priority, input interrupt_ready, output ready);
endinterface

@@ src/apic_interrupt_priority_core.sv @@
// Top level of the interrupt priority core: configuration port, controller and
// datapath. Depends on apic_pkg, apic_if, apic_ctrl and apic_dpath.
//
// One transaction is handled at a time. Every function does a scan of the request
// and in-service bitmaps after the update; acknowledge and end of interrupt also
// scan before it. Each scan reads one 32-bit word of each bitmap per cycle, from
// the highest word down. The next transaction is accepted as soon as the response
// registers are loaded, even while the response still waits to be taken.
// Register unit_enabled (bit 0 at byte address 0) is to be written through the APB
// port only while the core is idle; the core itself does not enforce this.
module apic_interrupt_priority_core (
   input  logic                              clock,
   input  logic                              reset,
   apic_req_if.sink                          req,
   apic_rsp_if.source                        rsp,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [apic_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [apic_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [apic_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready
);
   import apic_pkg::*;

   apic_cmd_type    cmd;
   apic_status_type status;
   logic            enable_ff, enable_in;
   logic            csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && (paddr[2] == CSR_IDX_UNIT_ENABLE);
   assign enable_in = csr_write ? pwdata[0] : enable_ff;
   assign prdata    = (paddr[2] == CSR_IDX_UNIT_ENABLE) ? CSR_DATA_W'(enable_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
      end else begin
         enable_ff <= enable_in;
      end
   end

   apic_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .status    (status),
      .cmd       (cmd)
   );

   apic_dpath u_dpath (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .status                 (status),
      .unit_enabled           (enable_ff),
      .req_func               (req.func),
      .req_vector             (req.vector),
      .req_task_priority      (req.task_priority),
      .rsp_accepted           (rsp.accepted),
      .rsp_vector_valid       (rsp.vector_valid),
      .rsp_vector_out         (rsp.vector_out),
      .rsp_processor_priority (rsp.processor_priority),
      .rsp_interrupt_ready    (rsp.interrupt_ready)
   );

endmodule

@@ src/apic_ctrl.sv @@
// Controller state machine of the interrupt priority core: sequences the bitmap
// scans, the update and the response. Depends on apic_pkg.
module apic_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  apic_pkg::apic_status_type status,
   output apic_pkg::apic_cmd_type   cmd
);
   import apic_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_SCAN1 = 5'b00010,
      ST_APPLY = 5'b00100,
      ST_SCAN2 = 5'b01000,
      ST_POST  = 5'b10000
   } apic_state_type;

   apic_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load       = 1'b1;
               cmd.scan_clear = 1'b1;
               state_in       = status.pre_scan ? ST_SCAN1 : ST_APPLY;
            end
         end
         ST_SCAN1: begin
            cmd.scan_step = 1'b1;
            if (status.scan_last) begin
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            cmd.apply      = 1'b1;
            cmd.scan_clear = 1'b1;
            state_in       = ST_SCAN2;
         end
         ST_SCAN2: begin
            cmd.scan_step = 1'b1;
            if (status.scan_last) begin
               state_in = ST_POST;
            end
         end
         ST_POST: begin
            if (out_free) begin
               cmd.post = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.post) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ src/apic_dpath.sv @@
// Datapath of the interrupt priority core: request and in-service bitmaps, the
// word scanner, the priority registers and the response registers. Depends on apic_pkg.
module apic_dpath (
   input  logic                           clock,
   input  logic                           reset,
   input  apic_pkg::apic_cmd_type         cmd,
   output apic_pkg::apic_status_type      status,
   input  logic                           unit_enabled,
   input  apic_pkg::apic_func_type        req_func,
   input  logic [apic_pkg::VEC_W-1:0]     req_vector,
   input  logic [apic_pkg::PRIO_W-1:0]    req_task_priority,
   output logic                           rsp_accepted,
   output logic                           rsp_vector_valid,
   output logic [apic_pkg::VEC_W-1:0]     rsp_vector_out,
   output logic [apic_pkg::PRIO_W-1:0]    rsp_processor_priority,
   output logic                           rsp_interrupt_ready
);
   import apic_pkg::*;

   apic_word_type       irr_ff [NUM_WORDS];
   apic_word_type       irr_in [NUM_WORDS];
   apic_word_type       isr_ff [NUM_WORDS];
   apic_word_type       isr_in [NUM_WORDS];
   logic [PRIO_W-1:0]   tpr_ff, tpr_in;
   logic [PRIO_W-1:0]   ppr_ff, ppr_in;

   apic_func_type       func_ff;
   logic [VEC_W-1:0]    vec_ff;
   logic [PRIO_W-1:0]   tp_ff;

   logic [WORD_IDX_W-1:0] idx_ff;
   logic                irr_found_ff, isr_found_ff;
   logic [VEC_W-1:0]    irr_vec_ff, isr_vec_ff;

   logic                accepted_ff, accepted_in;
   logic                valid_ff, valid_in;
   logic [VEC_W-1:0]    vout_ff, vout_in;
   logic [PRIO_W-1:0]   ppr_out_ff;
   logic                ready_ff, ready_in;

   apic_word_type       irr_word, isr_word;
   logic [VEC_W-1:0]    irr_hit, isr_hit;
   logic [VEC_W-1:0]    isv;
   logic                ack_ok;
   logic                raise_ok;

   assign status.pre_scan  = (req_func == FUNC_ACK) || (req_func == FUNC_EOI);
   assign status.scan_last = (idx_ff == '0);

   assign irr_word = irr_ff[idx_ff];
   assign isr_word = isr_ff[idx_ff];
   assign irr_hit  = VEC_W'({idx_ff, highest_bit(irr_word)});
   assign isr_hit  = VEC_W'({idx_ff, highest_bit(isr_word)});

   assign raise_ok = unit_enabled && (int'(vec_ff) < NUM_VECTORS);
   assign ack_ok   = irr_found_ff && ((irr_vec_ff & CLASS_MASK) > ppr_ff);

   always_comb begin
      for (int w = 0; w < NUM_WORDS; w++) begin
         irr_in[w] = irr_ff[w];
         isr_in[w] = isr_ff[w];
      end
      tpr_in      = tpr_ff;
      accepted_in = accepted_ff;
      valid_in    = valid_ff;
      vout_in     = vout_ff;
      if (cmd.load) begin
         accepted_in = 1'b0;
         valid_in    = 1'b0;
         vout_in     = '0;
      end else if (cmd.apply) begin
         unique case (func_ff)
            FUNC_RAISE: begin
               if (raise_ok) begin
                  irr_in[vec_ff[BIT_W +: WORD_IDX_W]][vec_ff[BIT_W-1:0]] = 1'b1;
                  accepted_in = 1'b1;
               end
            end
            FUNC_ACK: begin
               if (ack_ok) begin
                  irr_in[irr_vec_ff[BIT_W +: WORD_IDX_W]][irr_vec_ff[BIT_W-1:0]] = 1'b0;
                  isr_in[irr_vec_ff[BIT_W +: WORD_IDX_W]][irr_vec_ff[BIT_W-1:0]] = 1'b1;
                  valid_in = 1'b1;
                  vout_in  = irr_vec_ff;
               end
            end
            FUNC_EOI: begin
               if (isr_found_ff) begin
                  isr_in[isr_vec_ff[BIT_W +: WORD_IDX_W]][isr_vec_ff[BIT_W-1:0]] = 1'b0;
                  valid_in = 1'b1;
                  vout_in  = isr_vec_ff;
               end
            end
            FUNC_SET_TASK: begin
               tpr_in = tp_ff;
            end
            default: begin
               tpr_in = tpr_ff;
            end
         endcase
      end
   end

   // The processor priority follows the task priority unless the highest
   // in-service vector belongs to a higher class.
   always_comb begin
      isv      = isr_found_ff ? isr_vec_ff : '0;
      ppr_in   = ppr_ff;
      ready_in = ready_ff;
      if (cmd.post) begin
         if ((tpr_ff & CLASS_MASK) >= (isv & CLASS_MASK)) begin
            ppr_in = tpr_ff & PRIO_MASK;
         end else begin
            ppr_in = isv & CLASS_MASK;
         end
         ready_in = irr_found_ff && ((irr_vec_ff & CLASS_MASK) > ppr_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int w = 0; w < NUM_WORDS; w++) begin
            irr_ff[w] <= '0;
            isr_ff[w] <= '0;
         end
         tpr_ff <= '0;
         ppr_ff <= '0;
      end else begin
         for (int w = 0; w < NUM_WORDS; w++) begin
            irr_ff[w] <= irr_in[w];
            isr_ff[w] <= isr_in[w];
         end
         tpr_ff <= tpr_in;
         ppr_ff <= ppr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff <= req_func;
         vec_ff  <= req_vector;
         tp_ff   <= req_task_priority;
      end
      if (cmd.scan_clear) begin
         idx_ff       <= WORD_IDX_W'(NUM_WORDS - 1);
         irr_found_ff <= 1'b0;
         isr_found_ff <= 1'b0;
         irr_vec_ff   <= '0;
         isr_vec_ff   <= '0;
      end else if (cmd.scan_step) begin
         idx_ff <= idx_ff - 1'b1;
         if (!irr_found_ff && (irr_word != '0)) begin
            irr_found_ff <= 1'b1;
            irr_vec_ff   <= irr_hit;
         end
         if (!isr_found_ff && (isr_word != '0)) begin
            isr_found_ff <= 1'b1;
            isr_vec_ff   <= isr_hit;
         end
      end
      accepted_ff <= accepted_in;
      valid_ff    <= valid_in;
      vout_ff     <= vout_in;
      ready_ff    <= ready_in;
      if (cmd.post) begin
         ppr_out_ff           <= ppr_in;
         rsp_accepted         <= accepted_ff;
         rsp_vector_valid     <= valid_ff;
         rsp_vector_out       <= vout_ff;
      end
   end

   assign rsp_processor_priority = ppr_out_ff;
   assign rsp_interrupt_ready    = ready_ff;

endmodule

@@ src/apic_checker.sv @@
// Port-level checker for the interrupt priority core, bound to the top level.
// Depends on apic_pkg and on the top level's port names.
module apic_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic                           rsp_accepted,
   input logic                           rsp_vector_valid,
   input logic [apic_pkg::VEC_W-1:0]     rsp_vector_out
);
   import apic_pkg::*;

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response withdrawn before it was taken");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_accepted && rsp_vector_valid))
      else $error("raise and vector delivery reported in one transaction");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_vector_valid |-> (rsp_vector_out == '0))
      else $error("vector reported without a valid vector");

   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second transaction accepted while one is in progress");

endmodule

bind apic_interrupt_priority_core apic_checker u_apic_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req.valid),
   .req_ready        (req.ready),
   .rsp_valid        (rsp.valid),
   .rsp_ready        (rsp.ready),
   .rsp_accepted     (rsp.accepted),
   .rsp_vector_valid (rsp.vector_valid),
   .rsp_vector_out   (rsp.vector_out)
);
